FILE: hw/rtl/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types, codes and helpers for the finger query line checker.
// ----------------------------------------------------------------------------
package flc_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_HOP_LIMIT      = 8'd0;
    localparam logic [7:0] CFG_USER_LEN_LIMIT = 8'd1;
    localparam logic [7:0] CFG_HOST_LEN_LIMIT = 8'd2;
    localparam logic [7:0] CFG_STRICT_CHARS   = 8'd3;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;

    // Register reset values
    localparam logic signed [8:0] HOP_LIMIT_RST      = 9'sd0;
    localparam logic [7:0]        USER_LEN_LIMIT_RST = 8'd8;
    localparam logic [7:0]        HOST_LEN_LIMIT_RST = 8'd30;
    localparam logic              STRICT_CHARS_RST   = 1'b1;

    localparam logic signed [8:0] HOP_UNLIMITED = -9'sd1;

    // Parse phases
    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_SLASH = 3'd1;
    localparam logic [2:0] PH_MID   = 3'd2;
    localparam logic [2:0] PH_BODY  = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    // Verdict codes
    localparam logic [2:0] V_OK       = 3'd0;
    localparam logic [2:0] V_PARSE    = 3'd1;
    localparam logic [2:0] V_BADCHAR  = 3'd2;
    localparam logic [2:0] V_USERLONG = 3'd3;
    localparam logic [2:0] V_HOSTLONG = 3'd4;

    // Byte classes
    localparam logic [1:0] CLS_IGNORE = 2'd0;
    localparam logic [1:0] CLS_USER   = 2'd1;
    localparam logic [1:0] CLS_HOST   = 2'd2;

    // Character constants
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef struct packed {
        logic signed [8:0] hop_limit;
        logic [7:0]        user_len_limit;
        logic [7:0]        host_len_limit;
        logic              strict_chars;
    } t_cfg;

    typedef struct packed {
        logic [2:0] phase;
        logic       long_flag;
        logic       in_user_part;
        logic [8:0] hops_seen;
        logic [8:0] user_count;
        logic [8:0] host_count;
        logic [2:0] error_code;
    } t_line_state;

    localparam t_line_state LINE_STATE_RST = '{
        phase:        PH_LEAD,
        long_flag:    1'b0,
        in_user_part: 1'b1,
        hops_seen:    9'd0,
        user_count:   9'd0,
        host_count:   9'd0,
        error_code:   V_OK
    };

    // Strict-mode character set: alphanumerics and _ @ . -
    function automatic logic allowed_char(input logic [7:0] c);
        logic ok;
        ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER || c == CH_AT ||
             c == CH_DOT || c == CH_DASH;
        return ok;
    endfunction

endpackage

FILE: hw/rtl/flc_cfg.sv
// ----------------------------------------------------------------------------
// flc_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module flc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [flc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [flc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output flc_pkg::t_cfg                      o_cfg
);

    flc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hop_limit      <= flc_pkg::HOP_LIMIT_RST;
            r_cfg.user_len_limit <= flc_pkg::USER_LEN_LIMIT_RST;
            r_cfg.host_len_limit <= flc_pkg::HOST_LEN_LIMIT_RST;
            r_cfg.strict_chars   <= flc_pkg::STRICT_CHARS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                flc_pkg::CFG_HOP_LIMIT:      r_cfg.hop_limit      <= $signed(i_cfg_data);
                flc_pkg::CFG_USER_LEN_LIMIT: r_cfg.user_len_limit <= i_cfg_data[7:0];
                flc_pkg::CFG_HOST_LEN_LIMIT: r_cfg.host_len_limit <= i_cfg_data[7:0];
                flc_pkg::CFG_STRICT_CHARS:   r_cfg.strict_chars   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/flc_core.sv
// ----------------------------------------------------------------------------
// flc_core
// Input register, per-byte parse step with line state, result register.
// ----------------------------------------------------------------------------
module flc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  flc_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_line_byte,
    input  logic          i_line_end,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_echo_byte,
    output logic [1:0]    o_byte_class,
    output logic          o_long_request,
    output logic [2:0]    o_verdict,
    output logic          o_line_done
);

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // result stage
    logic       r_out_valid;
    logic [7:0] r_echo_byte;
    logic [1:0] r_byte_class;
    logic       r_long_request;
    logic [2:0] r_verdict;
    logic       r_line_done;

    flc_pkg::t_line_state r_st;
    flc_pkg::t_line_state n_st;
    flc_pkg::t_line_state st_step;
    logic [1:0]           step_class;
    logic                 body_go;
    logic                 hop_stop;
    logic                 advance;
    logic                 move;

    assign advance    = !r_out_valid || i_out_ready;
    assign move       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        st_step    = r_st;
        step_class = flc_pkg::CLS_IGNORE;
        body_go    = 1'b0;
        hop_stop   = 1'b0;

        if (r_st.error_code == flc_pkg::V_OK) begin
            unique case (r_st.phase)
                flc_pkg::PH_LEAD: begin
                    if (r_in_byte == flc_pkg::CH_SPACE) begin
                        st_step.phase = flc_pkg::PH_LEAD;
                    end else if (r_in_byte == flc_pkg::CH_SLASH) begin
                        st_step.phase = flc_pkg::PH_SLASH;
                        // line ends right after the slash: no W can follow
                        if (r_in_end) begin
                            st_step.error_code = flc_pkg::V_PARSE;
                        end
                    end else begin
                        body_go = 1'b1;
                    end
                end
                flc_pkg::PH_SLASH: begin
                    if (r_in_byte == flc_pkg::CH_W) begin
                        st_step.long_flag = 1'b1;
                        st_step.phase     = flc_pkg::PH_MID;
                    end else begin
                        st_step.error_code = flc_pkg::V_PARSE;
                    end
                end
                flc_pkg::PH_MID: begin
                    body_go = (r_in_byte != flc_pkg::CH_SPACE);
                end
                flc_pkg::PH_BODY: begin
                    body_go = 1'b1;
                end
                default: ;
            endcase
        end

        if (body_go) begin
            st_step.phase = flc_pkg::PH_BODY;
            if (r_in_byte == flc_pkg::CH_NUL) begin
                st_step.phase = flc_pkg::PH_STOP;
            end else begin
                if (r_in_byte == flc_pkg::CH_AT && i_cfg.hop_limit != flc_pkg::HOP_UNLIMITED) begin
                    st_step.hops_seen = r_st.hops_seen + 9'd1;
                    // hop count is non-negative, limit is signed
                    hop_stop = $signed({1'b0, st_step.hops_seen}) >
                               $signed({i_cfg.hop_limit[8], i_cfg.hop_limit});
                end
                if (hop_stop) begin
                    st_step.phase = flc_pkg::PH_STOP;
                end else begin
                    if (r_in_byte == flc_pkg::CH_AT) begin
                        st_step.in_user_part = 1'b0;
                        st_step.host_count   = 9'd0;
                    end
                    if (i_cfg.strict_chars && !flc_pkg::allowed_char(r_in_byte)) begin
                        st_step.error_code = flc_pkg::V_BADCHAR;
                    end else if (st_step.in_user_part) begin
                        st_step.user_count = r_st.user_count + 9'd1;
                        if (st_step.user_count > {1'b0, i_cfg.user_len_limit}) begin
                            st_step.error_code = flc_pkg::V_USERLONG;
                        end else begin
                            step_class = flc_pkg::CLS_USER;
                        end
                    end else if (st_step.host_count > {1'b0, i_cfg.host_len_limit}) begin
                        st_step.error_code = flc_pkg::V_HOSTLONG;
                    end else begin
                        st_step.host_count = st_step.host_count + 9'd1;
                        step_class         = flc_pkg::CLS_HOST;
                    end
                end
            end
        end

        n_st = r_in_end ? flc_pkg::LINE_STATE_RST : st_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= flc_pkg::LINE_STATE_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (move) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_line_byte;
            r_in_end  <= i_line_end;
        end
        if (move) begin
            r_echo_byte    <= r_in_byte;
            r_byte_class   <= step_class;
            r_long_request <= st_step.long_flag;
            r_verdict      <= st_step.error_code;
            r_line_done    <= r_in_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_echo_byte    = r_echo_byte;
    assign o_byte_class   = r_byte_class;
    assign o_long_request = r_long_request;
    assign o_verdict      = r_verdict;
    assign o_line_done    = r_line_done;

endmodule

FILE: hw/rtl/finger_query_line_checker_unit.sv
// ----------------------------------------------------------------------------
// finger_query_line_checker_unit
// Checks a finger query line one byte per transfer and classifies each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one line byte per
//   transfer, with i_line_end set on the last byte of the line (CRLF is
//   already stripped). Each input transfer yields exactly one result
//   transfer on the output channel (o_out_valid / i_out_ready): the echoed
//   byte, its class, the long-request flag, the running verdict and the
//   line-done mark, on which the verdict is final.
//   Configuration (i_cfg_valid / o_cfg_ready) writes one register per
//   transfer: 0 hop limit, 1 username limit, 2 hostname limit, 3 strict
//   mode. Other indexes are dropped. Write only while the block is idle.
//   The byte lands in the input register at its transfer and moves to the
//   result register when the output stage can advance; throughput is one
//   byte per cycle while the output does not stall, bounded by the single
//   parse step that updates the line state for each byte it moves.
//   The input register keeps taking a byte while a result waits, so one
//   byte is absorbed during an output stall before o_in_ready drops.
//   Reset (synchronous, active low) empties both stages, returns the line
//   state to the leading-space phase and loads register defaults.
// ----------------------------------------------------------------------------
module finger_query_line_checker_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [flc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [flc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // byte input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_line_byte,
    input  logic                               i_line_end,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_echo_byte,
    output logic [1:0]                         o_byte_class,
    output logic                               o_long_request,
    output logic [2:0]                         o_verdict,
    output logic                               o_line_done
);

    // register file feeding the parse step
    flc_pkg::t_cfg cfg;

    flc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // two-stage datapath: input register, parse step, result register
    flc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_byte    (i_line_byte),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_echo_byte    (o_echo_byte),
        .o_byte_class   (o_byte_class),
        .o_long_request (o_long_request),
        .o_verdict      (o_verdict),
        .o_line_done    (o_line_done)
    );

endmodule

FILE: hw/rtl/flc_checker.sv
// ----------------------------------------------------------------------------
// flc_checker
// Port-level assertions for the finger query line checker.
// ----------------------------------------------------------------------------
module flc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_echo_byte,
    input logic [1:0] o_byte_class,
    input logic [2:0] o_verdict
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_echo_byte))
        else $error("result changed while stalled");

    // an erroring line classifies no byte
    a_err_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict != flc_pkg::V_OK |-> o_byte_class == flc_pkg::CLS_IGNORE)
        else $error("classified byte under an error verdict");

    // class code stays within its three values
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_class != 2'd3)
        else $error("bad byte class");

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind finger_query_line_checker_unit flc_checker u_flc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_echo_byte  (o_echo_byte),
    .o_byte_class (o_byte_class),
    .o_verdict    (o_verdict)
);
